FILE: rtl/pcx_rle_pkg.sv
// shared types, constants and the run encoding function of the pcx line encoder
// no dependencies
package pcx_rle_pkg;

  localparam int unsigned PixelW        = 8;
  localparam int unsigned RunLenW       = 6;
  localparam int unsigned MaxCmdBytes   = 4;
  localparam int unsigned CmdCntW       = 3;
  localparam int unsigned MaxRunDefault = 63;
  localparam int unsigned CmdDepthDef   = 4;

  localparam logic [PixelW-1:0] RunTag  = 8'hC0;
  localparam logic [PixelW-1:0] EscByte = 8'hC1;

  typedef struct packed {
    logic [PixelW-1:0] pixel;
    logic              line_end;
  } pix_item_t;

  typedef struct packed {
    logic [PixelW-1:0] code_byte;
    logic              last_of_item;
  } code_item_t;

  // bytes written for one input, oldest in slot 0
  typedef struct packed {
    logic [CmdCntW-1:0]                 cnt;
    logic [MaxCmdBytes-1:0][PixelW-1:0] bytes;
  } enc_cmd_t;

  typedef struct packed {
    logic [1:0]        cnt;
    logic [PixelW-1:0] b0;
    logic [PixelW-1:0] b1;
  } run_code_t;

  // code for one finished run (length is never zero here)
  function automatic run_code_t enc_run(input logic [PixelW-1:0]  v,
                                        input logic [RunLenW-1:0] n);
    run_code_t r;
    r.b1 = v;
    if (n > RunLenW'(1)) begin
      r.cnt = 2'd2;
      r.b0  = RunTag | {2'b00, n};
    end else if (v[7:6] == 2'b11) begin
      r.cnt = 2'd2;
      r.b0  = EscByte;
    end else begin
      r.cnt = 2'd1;
      r.b0  = v;
    end
    return r;
  endfunction

endpackage

FILE: rtl/pcx_run_tracker.sv
// front part: holds the current run and turns each pixel that yields code bytes into a byte command
// depends on pcx_rle_pkg
module pcx_run_tracker #(
  parameter int unsigned MAX_RUN = pcx_rle_pkg::MaxRunDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  pcx_rle_pkg::pix_item_t item_i,
  output logic                  cmd_push_o,
  output pcx_rle_pkg::enc_cmd_t cmd_o
);
  import pcx_rle_pkg::*;

  localparam logic [RunLenW-1:0] MaxRunL = RunLenW'(MAX_RUN);

  logic [PixelW-1:0]  run_value_q, run_value_d;
  logic [RunLenW-1:0] run_length_q, run_length_d;
  logic [PixelW-1:0]  new_value;
  logic [RunLenW-1:0] new_length;
  logic               flush_old;
  run_code_t          code_old, code_new;
  logic [1:0]         cnt_old;

  always_comb begin
    flush_old = (run_length_q != '0) &&
                ((item_i.pixel != run_value_q) || (run_length_q >= MaxRunL));
    if ((run_length_q == '0) || flush_old) begin
      new_value  = item_i.pixel;
      new_length = RunLenW'(1);
    end else begin
      new_value  = run_value_q;
      new_length = run_length_q + RunLenW'(1);
    end
    code_old = enc_run(run_value_q, run_length_q);
    code_new = enc_run(new_value, new_length);
    cnt_old  = flush_old ? code_old.cnt : 2'd0;

    cmd_o.bytes = '0;
    if (flush_old) begin
      cmd_o.bytes[0] = code_old.b0;
      cmd_o.bytes[1] = code_old.b1;
    end
    if (item_i.line_end) begin
      case (cnt_old)
        2'd0: begin
          cmd_o.bytes[0] = code_new.b0;
          cmd_o.bytes[1] = code_new.b1;
        end
        2'd1: begin
          cmd_o.bytes[1] = code_new.b0;
          cmd_o.bytes[2] = code_new.b1;
        end
        default: begin
          cmd_o.bytes[2] = code_new.b0;
          cmd_o.bytes[3] = code_new.b1;
        end
      endcase
    end
    cmd_o.cnt = CmdCntW'(cnt_old) +
                (item_i.line_end ? CmdCntW'(code_new.cnt) : CmdCntW'(0));
    cmd_push_o = accept_i && (cmd_o.cnt != '0);

    run_value_d  = run_value_q;
    run_length_d = run_length_q;
    if (accept_i) begin
      run_value_d  = new_value;
      run_length_d = item_i.line_end ? '0 : new_length;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_value_q  <= '0;
      run_length_q <= '0;
    end else begin
      run_value_q  <= run_value_d;
      run_length_q <= run_length_d;
    end
  end

`ifndef SYNTH
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_length_q <= MaxRunL) else $error("run length above maximum");
  a_eol_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && item_i.line_end |=> run_length_q == '0)
    else $error("run held across line end");
  a_run_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !item_i.line_end |=> run_length_q != '0)
    else $error("pixel lost without line end");
`endif

endmodule

FILE: rtl/pcx_cmd_fifo.sv
// short command queue between the run tracker and the byte emitter
// depends on pcx_rle_pkg
module pcx_cmd_fifo #(
  parameter int unsigned DEPTH = pcx_rle_pkg::CmdDepthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_i,
  input  pcx_rle_pkg::enc_cmd_t wr_data_i,
  input  logic                  rd_i,
  output pcx_rle_pkg::enc_cmd_t rd_data_o,
  output logic                  full_o,
  output logic                  empty_o
);
  import pcx_rle_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] DepthC  = CntW'(DEPTH);

  enc_cmd_t           mem_q [DEPTH];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               do_wr, do_rd;

  assign full_o    = (count_q == DepthC);
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    if (do_rd) rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    if (do_wr && !do_rd) count_d = count_q + CntW'(1);
    else if (do_rd && !do_wr) count_d = count_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC) else $error("command count above depth");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_i && full_o)) else $error("command written into full queue");
  a_rd_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_rd && !do_wr |=> count_q == $past(count_q) - CntW'(1))
    else $error("command count wrong after read");
`endif

endmodule

FILE: rtl/pcx_byte_emitter.sv
// back part: walks the head command one byte a cycle into the result register while it is free or popped
// depends on pcx_rle_pkg
module pcx_byte_emitter (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    head_valid_i,
  input  pcx_rle_pkg::enc_cmd_t   head_i,
  output logic                    head_pop_o,
  output logic                    empty,
  input  logic                    pop,
  output pcx_rle_pkg::code_item_t result_o
);
  import pcx_rle_pkg::*;

  logic       out_valid_q, out_valid_d;
  code_item_t out_q, out_d;
  logic [1:0] idx_q, idx_d;
  logic       load, last_byte;

  assign empty    = !out_valid_q;
  assign result_o = out_q;

  always_comb begin
    load       = head_valid_i && (!out_valid_q || pop);
    last_byte  = ({1'b0, idx_q} == (head_i.cnt - CmdCntW'(1)));
    head_pop_o = load && last_byte;
    out_d.code_byte    = head_i.bytes[idx_q];
    out_d.last_of_item = last_byte;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      idx_d       = last_byte ? 2'd0 : idx_q + 2'd1;
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) out_q <= out_d;
  end

`ifndef SYNTH
  a_idx_in_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> {1'b0, idx_q} < head_i.cnt) else $error("byte index past command");
  a_cmd_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> head_i.cnt != '0 && head_i.cnt <= CmdCntW'(MaxCmdBytes))
    else $error("command byte count out of range");
  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_valid_i |-> idx_q == 2'd0) else $error("byte index left over");
`endif

endmodule

FILE: rtl/pcx_rle_line_encoder.sv
// top level of the pcx run-length line encoder
// depends on pcx_rle_pkg, pcx_run_tracker, pcx_cmd_fifo, pcx_byte_emitter
//
// usage
//   input channel: one pixel request per cycle while full is low, item_i carries the
//   pixel and a line end flag; taken at a rising edge with push high and full low
//   result channel: queue style, the oldest code byte sits on result_o while
//   empty is low and is taken at a rising edge with pop high
//   each request gives zero to four code bytes; last_of_item marks the final
//   byte of a request, a request that only extends or starts a run gives none
//   throughput: one request per cycle while full is low, limited by the byte
//   emitter, which moves one code byte per cycle while the receiver pops; bursts
//   of up to four bytes are absorbed by the command queue of CMD_DEPTH entries
//   path: the first byte of a request is written into the command queue at the
//   taking edge, then into the result register once it is free or popped
//   reset: asynchronous active low, clears the held run and the queue, empties
//   the result register; no clearing pass, the block is ready right after reset
//   receiver stall: a waiting byte holds on result_o, the emitter stops, the
//   queue fills and full rises, backpressuring the pixel source
module pcx_rle_line_encoder #(
  parameter int unsigned MAX_RUN   = pcx_rle_pkg::MaxRunDefault,
  parameter int unsigned CMD_DEPTH = pcx_rle_pkg::CmdDepthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  pcx_rle_pkg::pix_item_t  item_i,
  output logic                    empty,
  input  logic                    pop,
  output pcx_rle_pkg::code_item_t result_o
);
  import pcx_rle_pkg::*;

  // request taken when the command queue has room, even for a byteless pixel
  logic     accept;
  logic     cmd_push;
  enc_cmd_t cmd_wr, cmd_head;
  logic     cmd_empty, cmd_pop;

  assign accept = push && !full;

  // front: run state and byte command forming
  pcx_run_tracker #(
    .MAX_RUN (MAX_RUN)
  ) u_tracker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (item_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_wr)
  );

  // decoupling queue
  pcx_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (cmd_push),
    .wr_data_i (cmd_wr),
    .rd_i      (cmd_pop),
    .rd_data_o (cmd_head),
    .full_o    (full),
    .empty_o   (cmd_empty)
  );

  // back: byte serializer with its result register
  pcx_byte_emitter u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!cmd_empty),
    .head_i       (cmd_head),
    .head_pop_o   (cmd_pop),
    .empty        (empty),
    .pop          (pop),
    .result_o     (result_o)
  );

endmodule
